>>> rtl/refcounted_page_allocator_assert.svh
// Assertion macros shared by the page allocator RTL.
// No dependencies; include inside a module body after the package import.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpa assertion failed");
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpa assertion failed");
`else
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/rpa_pkg.sv
// Shared types and constants of the reference-counted page allocator.
// No dependencies; imported by every allocator module.
`timescale 1ns / 1ps
package rpa_pkg;

    localparam int NPAGES  = 4096;
    localparam int PAGE_W  = $clog2(NPAGES);
    localparam int TOTAL_W = $clog2(NPAGES + 1);
    localparam int CNT_W   = 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [CNT_W-1:0]   t_count;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SHARE = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_NULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic  rd;
        logic  pop;
        logic  push;
        t_page ret_page;
    } t_stk_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

    typedef struct packed {
        logic   rd_en;
        t_page  rd_addr;
        logic   wr_en;
        t_page  wr_addr;
        t_count wr_data;
    } t_cnt_req;

endpackage

>>> rtl/rpa_free_stack.sv
// LIFO free-page stack in a synchronous RAM with a registered read.
// Depends on rpa_pkg. Entries below the low-water mark read as their own index.
`timescale 1ns / 1ps
module rpa_free_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_init,
    input  rpa_pkg::t_total    i_init_depth,
    input  rpa_pkg::t_stk_req  i_req,
    output rpa_pkg::t_stk_stat o_stat,
    output rpa_pkg::t_page     o_top
);
    import rpa_pkg::*;
    `include "refcounted_page_allocator_assert.svh"

    t_page  r_mem [NPAGES];
    t_page  r_q;
    t_page  r_rd_addr;
    t_total r_depth;
    t_total r_low;
    t_total n_low;
    t_page  w_rd_addr;
    logic   w_wr;

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth == TOTAL_W'(NPAGES));
    assign w_rd_addr    = PAGE_W'(r_depth - TOTAL_W'(1));
    assign w_wr         = i_req.push && !o_stat.full;
    assign n_low        = (r_depth < r_low) ? r_depth : r_low;

    // never-written entries read as their own index: page i at entry i
    assign o_top = ({1'b0, r_rd_addr} >= r_low) ? r_q : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_depth[PAGE_W-1:0]] <= i_req.ret_page;
        end
        if (i_req.rd) begin
            r_q       <= r_mem[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= TOTAL_W'(NPAGES);
            r_low   <= TOTAL_W'(NPAGES);
        end else if (i_init) begin
            r_depth <= i_init_depth;
            r_low   <= TOTAL_W'(NPAGES);
        end else if (i_req.pop && !o_stat.empty) begin
            r_depth <= r_depth - TOTAL_W'(1);
        end else if (w_wr) begin
            r_depth <= r_depth + TOTAL_W'(1);
            r_low   <= n_low;
        end
    end

    `RPA_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, i_req.pop, !o_stat.empty)
    `RPA_ASSERT_IMP(a_no_push_pop, i_clk, i_rst_n, i_req.push, !i_req.pop)
    `RPA_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= TOTAL_W'(NPAGES))

endmodule

>>> rtl/rpa_ref_ram.sv
// Reference-count RAM, one 8-bit count per page, with a registered read.
// Depends on rpa_pkg. Zeroes the managed pages one by one in a sweep after reset and init.
`timescale 1ns / 1ps
module rpa_ref_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  rpa_pkg::t_total   i_init_count,
    input  rpa_pkg::t_cnt_req i_req,
    output rpa_pkg::t_count   o_rd_data,
    output logic              o_clearing
);
    import rpa_pkg::*;
    `include "refcounted_page_allocator_assert.svh"

    t_count r_mem [NPAGES];
    t_count r_q;
    logic   r_clearing;
    t_page  r_clr_idx;
    t_page  r_clr_last;

    assign o_rd_data  = r_q;
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_clr_last <= PAGE_W'(NPAGES - 1);
        end else if (i_init) begin
            // restart the sweep over the new page range
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_clr_last <= PAGE_W'(i_init_count - TOTAL_W'(1));
        end else if (r_clearing) begin
            if (r_clr_idx == r_clr_last) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + PAGE_W'(1);
            end
        end
    end

    `RPA_ASSERT_IMP(a_no_wr_in_clear, i_clk, i_rst_n, r_clearing, !i_req.wr_en)
    `RPA_ASSERT_IMP(a_no_rd_in_clear, i_clk, i_rst_n, r_clearing, !i_req.rd_en)
    `RPA_ASSERT_IMP(a_clr_bound, i_clk, i_rst_n, r_clearing, r_clr_idx <= r_clr_last)

endmodule

>>> rtl/refcounted_page_allocator.sv
// A command accepted in S_IDLE is evaluated in S_EXEC; its result is registered and
// strobed on o_done. No command is taken in S_EXEC (read-modify-write on the count RAM).
// Reset (synchronous, active low) and each page_count write zero the counts in a sweep
// over the managed pages (all 4096 after reset); o_busy stays high for the sweep.
// The free stack restarts holding every managed page with no sweep. Results cannot stall.
`timescale 1ns / 1ps
module refcounted_page_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [1:0]               i_cmd,
    input  logic [rpa_pkg::PAGE_W-1:0] i_page_index,
    input  logic                     i_page_present,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [rpa_pkg::TOTAL_W-1:0] i_cfg_data,
    output logic                     o_done,
    output logic [rpa_pkg::PAGE_W-1:0] o_result_page,
    output logic [1:0]               o_status,
    output logic                     o_copy_needed,
    output logic                     o_page_released,
    output logic [rpa_pkg::CNT_W-1:0] o_ref_count,
    output logic [rpa_pkg::TOTAL_W-1:0] o_pages_in_use
);
    import rpa_pkg::*;
    `include "refcounted_page_allocator_assert.svh"

    t_state    r_state, n_state;
    t_cmd      r_cmd;
    t_page     r_pg;
    logic      r_present;
    t_total    r_page_count;
    t_total    r_total, n_total;
    logic      r_done;
    t_page     r_res_page, n_res_page;
    t_status   r_status, n_status;
    logic      r_copy, n_copy;
    logic      r_rel, n_rel;
    t_count    r_res_cnt, n_res_cnt;

    logic      w_accept;
    logic      w_cfg_wr;
    logic      w_clearing;
    t_total    w_cfg_clamped;
    t_stk_req  w_stk_req;
    t_stk_stat w_stk_stat;
    t_page     w_top;
    t_cnt_req  w_cnt_req;
    t_count    w_cnt;
    logic      w_valid_pg;
    logic      x_pop, x_push, x_wr;
    t_page     x_wr_addr;
    t_count    x_wr_data;

    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        w_cfg_clamped = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_cfg_clamped = TOTAL_W'(1);
        end else if (i_cfg_data > TOTAL_W'(NPAGES)) begin
            w_cfg_clamped = TOTAL_W'(NPAGES);
        end
    end

    rpa_free_stack u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (w_cfg_wr),
        .i_init_depth (w_cfg_clamped),
        .i_req        (w_stk_req),
        .o_stat       (w_stk_stat),
        .o_top        (w_top)
    );

    rpa_ref_ram u_counts (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (w_cfg_wr),
        .i_init_count (w_cfg_clamped),
        .i_req        (w_cnt_req),
        .o_rd_data    (w_cnt),
        .o_clearing   (w_clearing)
    );

    // command evaluation, valid while in S_EXEC with both RAM reads returned
    assign w_valid_pg = r_present && ({1'b0, r_pg} < r_page_count);

    always_comb begin
        n_res_page = '0;
        n_status   = ST_OK;
        n_copy     = 1'b0;
        n_rel      = 1'b0;
        n_res_cnt  = '0;
        n_total    = r_total;
        x_pop      = 1'b0;
        x_push     = 1'b0;
        x_wr       = 1'b0;
        x_wr_addr  = r_pg;
        x_wr_data  = '0;
        unique case (r_cmd)
            CMD_GET: begin
                if (w_stk_stat.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    x_pop      = 1'b1;
                    x_wr       = 1'b1;
                    x_wr_addr  = w_top;
                    x_wr_data  = CNT_W'(1);
                    n_res_page = w_top;
                    n_res_cnt  = CNT_W'(1);
                    n_total    = r_total + TOTAL_W'(1);
                end
            end
            CMD_FREE: begin
                if (!r_present) begin
                    n_status = ST_NULL;
                end else if (!w_valid_pg || w_cnt == '0) begin
                    n_status = ST_BAD;
                end else begin
                    x_wr       = 1'b1;
                    x_wr_data  = w_cnt - CNT_W'(1);
                    n_res_page = r_pg;
                    n_res_cnt  = w_cnt - CNT_W'(1);
                    if (w_cnt == CNT_W'(1)) begin
                        x_push = 1'b1;
                        n_rel  = 1'b1;
                        if (r_total != '0) begin
                            n_total = r_total - TOTAL_W'(1);
                        end
                    end
                end
            end
            CMD_SHARE: begin
                if (!w_valid_pg || w_cnt == '0) begin
                    n_status = ST_BAD;
                end else if (w_cnt < COUNT_MAX) begin
                    x_wr       = 1'b1;
                    x_wr_data  = w_cnt + CNT_W'(1);
                    n_res_page = r_pg;
                    n_res_cnt  = w_cnt + CNT_W'(1);
                end else if (!w_stk_stat.empty) begin
                    // saturated: hand out a fresh page for a copy
                    x_pop      = 1'b1;
                    x_wr       = 1'b1;
                    x_wr_addr  = w_top;
                    x_wr_data  = CNT_W'(1);
                    n_res_page = w_top;
                    n_res_cnt  = CNT_W'(1);
                    n_copy     = 1'b1;
                    n_total    = r_total + TOTAL_W'(1);
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_busy              = w_clearing;
        o_cfg_ready         = 1'b0;
        w_stk_req           = '0;
        w_cnt_req           = '0;
        w_cnt_req.rd_addr   = i_page_index;
        w_stk_req.ret_page  = r_pg;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready       = 1'b1;
                w_stk_req.rd      = i_start && !w_clearing;
                w_cnt_req.rd_en   = i_start && !w_clearing;
            end
            S_EXEC: begin
                o_busy            = 1'b1;
                w_stk_req.pop     = x_pop;
                w_stk_req.push    = x_push;
                w_cnt_req.wr_en   = x_wr;
                w_cnt_req.wr_addr = x_wr_addr;
                w_cnt_req.wr_data = x_wr_data;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_page_count <= TOTAL_W'(NPAGES);
            r_total      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
            if (w_cfg_wr) begin
                r_page_count <= w_cfg_clamped;
                r_total      <= '0;
            end else if (r_state == S_EXEC) begin
                r_total <= n_total;
            end
        end
    end

    // hold the command and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_pg      <= i_page_index;
            r_present <= i_page_present;
        end
        if (r_state == S_EXEC) begin
            r_res_page <= n_res_page;
            r_status   <= n_status;
            r_copy     <= n_copy;
            r_rel      <= n_rel;
            r_res_cnt  <= n_res_cnt;
        end
    end

    assign o_done          = r_done;
    assign o_result_page   = r_res_page;
    assign o_status        = r_status;
    assign o_copy_needed   = r_copy;
    assign o_page_released = r_rel;
    assign o_ref_count     = r_res_cnt;
    assign o_pages_in_use  = r_total;

    `RPA_ASSERT_NXT(a_exec_done, i_clk, i_rst_n, r_state == S_EXEC, o_done)
    `RPA_ASSERT_IMP(a_done_after_exec, i_clk, i_rst_n, o_done, $past(r_state == S_EXEC))
    `RPA_ASSERT_IMP(a_in_use_bound, i_clk, i_rst_n, 1'b1, r_total <= r_page_count)
    `RPA_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, o_done && (o_status != ST_OK),
                    o_result_page == '0 && o_ref_count == '0 && !o_copy_needed &&
                    !o_page_released)

endmodule

>>> tb/tb_refcounted_page_allocator.sv
// Self-checking testbench for the reference-counted page allocator.
// Depends on rpa_pkg and refcounted_page_allocator; the expected results come
// from a predictor of the free stack and the per-page counts kept in this file.
`timescale 1ns / 1ps
module tb_refcounted_page_allocator;
    import rpa_pkg::*;

    localparam int CLK_PERIOD_NS = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_GAP       = 18;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 7;
    localparam int PRINT_CAP     = 100;

    // Page count per random phase; the last two are drawn at run time.
    localparam int PHASE_PAGES [PHASES] = '{8191, 2, 5, 4096, 1, 0, 0};
    localparam int PHASE_ITEMS [PHASES] = '{200, 300, 200, 150, 100, 150, 150};
    localparam int SATURATE_PHASE = 1;

    typedef struct packed {
        t_page   page;
        t_status status;
        logic    copy;
        logic    released;
        t_count  count;
        t_total  in_use;
    } page_outcome_t;

    typedef struct {
        bit            is_cfg;
        t_total        cfg_value;
        t_cmd          cmd;
        t_page         page;
        bit            present;
        bit            typed;
        page_outcome_t want;
    } stim_row_t;

    localparam page_outcome_t NO_CHECK = '{12'd0, ST_OK, 1'b0, 1'b0, 8'd0, 13'd0};

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_start;
    logic   o_busy;
    logic   [1:0] i_cmd;
    t_page  i_page_index;
    logic   i_page_present;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    t_total i_cfg_data;
    logic   o_done;
    t_page  o_result_page;
    logic   [1:0] o_status;
    logic   o_copy_needed;
    logic   o_page_released;
    t_count o_ref_count;
    t_total o_pages_in_use;

    refcounted_page_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_page_index   (i_page_index),
        .i_page_present (i_page_present),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_result_page  (o_result_page),
        .o_status       (o_status),
        .o_copy_needed  (o_copy_needed),
        .o_page_released(o_page_released),
        .o_ref_count    (o_ref_count),
        .o_pages_in_use (o_pages_in_use)
    );

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    // Allocator state as the testbench sees it.
    t_page  free_pages [NPAGES];
    t_total stack_top;
    t_count page_refs [NPAGES];
    t_total live_total;
    t_total managed_pages;

    page_outcome_t pending_outcomes [$];
    page_outcome_t next_typed_outcome;
    bit            next_typed;
    bit            no_idle_run;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    stim_row_t     directed_rows [DIRECTED_ROWS];

    function automatic void set_page_count(t_total value);
        if (value == 0)
            managed_pages = 1;
        else if (value > t_total'(NPAGES))
            managed_pages = t_total'(NPAGES);
        else
            managed_pages = value;
        for (int p = 0; p < NPAGES; p++) begin
            free_pages[p] = t_page'(p);
            page_refs[p]  = '0;
        end
        stack_top  = managed_pages;
        live_total = '0;
    endfunction

    // Caller makes sure the stack is not empty.
    function automatic t_page take_free_page();
        t_page pg;
        stack_top     = stack_top - 1'b1;
        pg            = free_pages[stack_top[PAGE_W-1:0]];
        page_refs[pg] = 8'd1;
        live_total    = live_total + 1'b1;
        return pg;
    endfunction

    function automatic page_outcome_t apply_command(t_cmd cmd, t_page pg, logic present);
        page_outcome_t r;
        bit            usable;
        r      = NO_CHECK;
        usable = present && (t_total'(pg) < managed_pages);
        case (cmd)
            CMD_GET: begin
                if (stack_top == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.page  = take_free_page();
                    r.count = 8'd1;
                end
            end
            CMD_FREE: begin
                if (!present) begin
                    r.status = ST_NULL;
                end else if (!usable || page_refs[pg] == 0) begin
                    r.status = ST_BAD;
                end else begin
                    page_refs[pg] = page_refs[pg] - 1'b1;
                    r.page  = pg;
                    r.count = page_refs[pg];
                    if (page_refs[pg] == 0) begin
                        if (stack_top < t_total'(NPAGES)) begin
                            free_pages[stack_top[PAGE_W-1:0]] = pg;
                            stack_top = stack_top + 1'b1;
                        end
                        if (live_total != 0)
                            live_total = live_total - 1'b1;
                        r.released = 1'b1;
                    end
                end
            end
            CMD_SHARE: begin
                if (!usable || page_refs[pg] == 0) begin
                    r.status = ST_BAD;
                end else if (page_refs[pg] < COUNT_MAX) begin
                    page_refs[pg] = page_refs[pg] + 1'b1;
                    r.page  = pg;
                    r.count = page_refs[pg];
                end else if (stack_top != 0) begin
                    // saturated count: hand out a fresh page to copy into
                    r.page  = take_free_page();
                    r.count = 8'd1;
                    r.copy  = 1'b1;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: r.status = ST_BAD;
        endcase
        r.in_use = live_total;
        return r;
    endfunction

    // Any page with a nonzero count, or the one with the highest count.
    function automatic t_page pick_live_page(bit hottest);
        int     origin;
        int     idx;
        t_page  found;
        t_count best;
        origin = $urandom_range(0, managed_pages - 1);
        found  = t_page'(origin);
        best   = '0;
        for (int k = 0; k < managed_pages; k++) begin
            idx = (origin + k) % managed_pages;
            if (page_refs[idx] > best) begin
                found = t_page'(idx);
                best  = page_refs[idx];
                if (!hottest)
                    break;
            end
        end
        return found;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        page_outcome_t got;
        page_outcome_t want;
        page_outcome_t model;
        cycle_count <= cycle_count + 1;
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                got = '{o_result_page, t_status'(o_status), o_copy_needed,
                        o_page_released, o_ref_count, o_pages_in_use};
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("result strobed with no command outstanding");
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.page !== want.page)
                        report_mismatch($sformatf("result_page %0d, expected %0d",
                                                  got.page, want.page));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.copy !== want.copy)
                        report_mismatch($sformatf("copy_needed %0d, expected %0d",
                                                  got.copy, want.copy));
                    if (got.released !== want.released)
                        report_mismatch($sformatf("page_released %0d, expected %0d",
                                                  got.released, want.released));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("ref_count %0d, expected %0d",
                                                  got.count, want.count));
                    if (got.in_use !== want.in_use)
                        report_mismatch($sformatf("pages_in_use %0d, expected %0d",
                                                  got.in_use, want.in_use));
                end
            end
            if (i_start === 1'b1 && o_busy === 1'b0) begin
                model = apply_command(t_cmd'(i_cmd), i_page_index, i_page_present);
                pending_outcomes.push_back(next_typed ? next_typed_outcome : model);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the command is accepted.
    task automatic issue_command(t_cmd cmd, t_page pg, bit present, bit typed,
                                 page_outcome_t want);
        int gap;
        gap = no_idle_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start            <= 1'b1;
        i_cmd              <= cmd;
        i_page_index       <= pg;
        i_page_present     <= present;
        next_typed         = typed;
        next_typed_outcome = want;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic write_page_count(t_total value);
        i_start <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        set_page_count(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_command(bit saturate);
        int    roll;
        t_page pg;
        roll = $urandom_range(0, 99);
        if (roll < (saturate ? 5 : 30)) begin
            issue_command(CMD_GET, t_page'($urandom_range(0, NPAGES - 1)),
                          $urandom_range(0, 1), 1'b0, NO_CHECK);
        end else if (roll < (saturate ? 7 : 60)) begin
            issue_command(CMD_FREE, pick_live_page(1'b0), 1'b1, 1'b0, NO_CHECK);
        end else if (roll < (saturate ? 95 : 80)) begin
            issue_command(CMD_SHARE, pick_live_page(saturate), 1'b1, 1'b0, NO_CHECK);
        end else begin
            // noise: any command, any page, null or not
            if ($urandom_range(0, 1) == 0)
                pg = t_page'($urandom_range(0, NPAGES - 1));
            else
                pg = t_page'($urandom_range(0, managed_pages - 1));
            issue_command(t_cmd'($urandom_range(0, 3)), pg, $urandom_range(0, 1),
                          1'b0, NO_CHECK);
        end
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_total value;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_cmd          = CMD_GET;
        i_page_index   = '0;
        i_page_present = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        next_typed     = 1'b0;
        next_typed_outcome = NO_CHECK;
        no_idle_run    = 1'b0;
        set_page_count(t_total'(NPAGES));

        directed_rows = '{
            '{0, 0, CMD_GET,   12'd0,    1, 1, '{12'd4095, ST_OK,    0, 0, 8'd1, 13'd1}},
            '{0, 0, CMD_GET,   12'd0,    1, 1, '{12'd4094, ST_OK,    0, 0, 8'd1, 13'd2}},
            '{0, 0, CMD_SHARE, 12'd4095, 1, 1, '{12'd4095, ST_OK,    0, 0, 8'd2, 13'd2}},
            '{0, 0, CMD_FREE,  12'd4095, 1, 1, '{12'd4095, ST_OK,    0, 0, 8'd1, 13'd2}},
            '{0, 0, CMD_FREE,  12'd4095, 1, 1, '{12'd4095, ST_OK,    0, 1, 8'd0, 13'd1}},
            '{0, 0, CMD_FREE,  12'd4095, 1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_FREE,  12'd4094, 0, 1, '{12'd0,    ST_NULL,  0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_SHARE, 12'd4094, 0, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_RSVD,  12'd4094, 1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_SHARE, 12'd0,    1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_GET,   12'd4095, 0, 1, '{12'd4095, ST_OK,    0, 0, 8'd1, 13'd2}},
            '{0, 0, CMD_FREE,  12'd4094, 1, 1, '{12'd4094, ST_OK,    0, 1, 8'd0, 13'd1}},
            '{0, 0, CMD_SHARE, 12'd4095, 1, 0, NO_CHECK},
            '{1, 0, CMD_GET,   12'd0,    0, 0, NO_CHECK},
            '{0, 0, CMD_GET,   12'd0,    1, 1, '{12'd0,    ST_OK,    0, 0, 8'd1, 13'd1}},
            '{0, 0, CMD_GET,   12'd0,    1, 1, '{12'd0,    ST_EMPTY, 0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_SHARE, 12'd0,    1, 1, '{12'd0,    ST_OK,    0, 0, 8'd2, 13'd1}},
            '{0, 0, CMD_FREE,  12'd4095, 1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_FREE,  12'd1,    1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd1}},
            '{0, 0, CMD_FREE,  12'd0,    1, 0, NO_CHECK},
            '{0, 0, CMD_FREE,  12'd0,    1, 1, '{12'd0,    ST_OK,    0, 1, 8'd0, 13'd0}},
            '{0, 0, CMD_FREE,  12'd0,    0, 1, '{12'd0,    ST_NULL,  0, 0, 8'd0, 13'd0}},
            '{0, 0, CMD_SHARE, 12'd0,    1, 1, '{12'd0,    ST_BAD,   0, 0, 8'd0, 13'd0}},
            '{1, 8191, CMD_GET, 12'd0,   0, 0, NO_CHECK},
            '{0, 0, CMD_GET,   12'd0,    1, 1, '{12'd4095, ST_OK,    0, 0, 8'd1, 13'd1}}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                write_page_count(directed_rows[r].cfg_value);
            else
                issue_command(directed_rows[r].cmd, directed_rows[r].page,
                              directed_rows[r].present, directed_rows[r].typed,
                              directed_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 2)
                value = t_total'($urandom_range(1, 64));
            else if (ph == PHASES - 1)
                value = t_total'($urandom_range(0, 8191));
            else
                value = t_total'(PHASE_PAGES[ph]);
            write_page_count(value);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                // every 32 commands, pick back-to-back commands or idle gaps at random
                if (n % 32 == 0)
                    no_idle_run = ($urandom_range(0, 3) == 0);
                random_command(ph == SATURATE_PHASE);
            end
        end

        i_start <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
